/* design/gaussian_kernel_classifier_unit_assert.svh */
// Assertion macros shared by the classifier modules.
`ifndef GAUSSIAN_KERNEL_CLASSIFIER_UNIT_ASSERT_SVH
`define GAUSSIAN_KERNEL_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define GKC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gkc assertion failed");

// next-cycle implication
`define GKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gkc assertion failed");

`endif

/* design/gkc_pkg.sv */
// Shared types, constants and kernel tables of the Gaussian kernel classifier.
package gkc_pkg;

    localparam int FEATURE_COUNT      = 8;
    localparam int MAX_CLASSES        = 8;
    localparam int EXAMPLES_PER_CLASS = 16;

    localparam int STORE_DEPTH = MAX_CLASSES * EXAMPLES_PER_CLASS * FEATURE_COUNT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_W       = $clog2(FEATURE_COUNT + 1);
    localparam int EL_W        = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CNT_W       = $clog2(EXAMPLES_PER_CLASS + 1);
    localparam int CLS_W       = $clog2(MAX_CLASSES + 1);
    localparam int CIX_W       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int ACT_W       = (CLS_W > 4) ? CLS_W : 4;
    localparam int DIST_W      = 32 + $clog2(FEATURE_COUNT);
    localparam int SUM_W       = 24;
    localparam int TOTAL_W     = SUM_W + $clog2(MAX_CLASSES);
    localparam int REM_W       = TOTAL_W + 1;
    localparam int QUO_W       = 17;
    localparam int DCNT_W      = 5;
    localparam int INT_STEPS   = 12;

    localparam logic [1:0] CFG_INV_SIGMA   = 2'd0;
    localparam logic [1:0] CFG_CALIBRATING = 2'd1;
    localparam logic [1:0] CFG_CLASS_COUNT = 2'd2;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [2:0]        class_index;
        logic signed [15:0] feature_value;
        logic              last_element;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  winner_class;
        logic [15:0] winner_probability;
        logic        no_winner;
        logic        skipped;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLS, ST_READ, ST_SQ, ST_ACC, ST_KMUL, ST_KEXP, ST_KACC,
        ST_CLEND, ST_DIV, ST_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic rd;
        logic sq;
        logic acc;
        logic kmul;
        logic kexp;
        logic kacc;
        logic clend;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic query_end;
        logic calibrating;
        logic cls_done;
        logic ex_done;
        logic elem_last;
        logic div_last;
        logic out_free;
    } status_t;

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_frac(input logic [3:0] f);
        logic [16:0] v;
        case (f)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

endpackage

/* design/gaussian_kernel_classifier_unit.sv */
// Top level of the Gaussian kernel classifier: sequencer plus datapath.
//
//  channel | ports                              | direction
//  input   | s_valid s_ready s_word             | in
//  result  | m_valid m_ready m_word             | out
//  config  | cfg_valid cfg_ready cfg_index/data | in
//
//  Store words and non-final query words are taken without leaving the idle state.
//  A final query word walks every stored example of the active classes (read,
//  square, accumulate per element; kernel multiply, exponent, accumulate per
//  example; class end per class), then a restoring divide and the result load.
//  During calibration a final query word goes straight to the load cycle.
//  Reset is synchronous; a waiting result holds the load and stalls the input channel.
module gaussian_kernel_classifier_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gkc_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output gkc_pkg::out_word_t m_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    gkc_pkg::cmd_t    cmd;
    gkc_pkg::status_t st;

    assign s_ready   = cmd.take && aresetn;
    assign cfg_ready = aresetn;

    gkc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd)
    );

    gkc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_valid   (s_valid),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* design/gkc_ctrl.sv */
// Sequencer of the classifier: input intake, example walk, division, result hand-off.
`include "gaussian_kernel_classifier_unit_assert.svh"

module gkc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  gkc_pkg::status_t  st,
    output gkc_pkg::cmd_t     cmd
);

    gkc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gkc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gkc_pkg::ST_IDLE: begin
                if (st.query_end) begin
                    state_next = st.calibrating ? gkc_pkg::ST_DONE : gkc_pkg::ST_CLS;
                end
            end
            gkc_pkg::ST_CLS: begin
                if (st.cls_done) begin
                    state_next = gkc_pkg::ST_DIV;
                end else if (st.ex_done) begin
                    state_next = gkc_pkg::ST_CLEND;
                end else begin
                    state_next = gkc_pkg::ST_READ;
                end
            end
            gkc_pkg::ST_READ:  state_next = gkc_pkg::ST_SQ;
            gkc_pkg::ST_SQ:    state_next = gkc_pkg::ST_ACC;
            gkc_pkg::ST_ACC:   state_next = st.elem_last ? gkc_pkg::ST_KMUL : gkc_pkg::ST_READ;
            gkc_pkg::ST_KMUL:  state_next = gkc_pkg::ST_KEXP;
            gkc_pkg::ST_KEXP:  state_next = gkc_pkg::ST_KACC;
            gkc_pkg::ST_KACC:  state_next = gkc_pkg::ST_CLS;
            gkc_pkg::ST_CLEND: state_next = gkc_pkg::ST_CLS;
            gkc_pkg::ST_DIV:   state_next = st.div_last ? gkc_pkg::ST_DONE : gkc_pkg::ST_DIV;
            gkc_pkg::ST_DONE:  state_next = st.out_free ? gkc_pkg::ST_IDLE : gkc_pkg::ST_DONE;
            default:           state_next = gkc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            gkc_pkg::ST_IDLE:  cmd.take = 1'b1;
            gkc_pkg::ST_CLS:   cmd.div_init = st.cls_done;
            gkc_pkg::ST_READ:  cmd.rd = 1'b1;
            gkc_pkg::ST_SQ:    cmd.sq = 1'b1;
            gkc_pkg::ST_ACC:   cmd.acc = 1'b1;
            gkc_pkg::ST_KMUL:  cmd.kmul = 1'b1;
            gkc_pkg::ST_KEXP:  cmd.kexp = 1'b1;
            gkc_pkg::ST_KACC:  cmd.kacc = 1'b1;
            gkc_pkg::ST_CLEND: cmd.clend = 1'b1;
            gkc_pkg::ST_DIV:   cmd.div_step = 1'b1;
            gkc_pkg::ST_DONE:  cmd.out_load = st.out_free;
            default:           cmd = '0;
        endcase
    end

    `GKC_ASSERT_NEXT(a_div_runs_to_end, aclk, aresetn, cmd.div_init, state_reg == gkc_pkg::ST_DIV)
    `GKC_ASSERT_NOW(a_load_needs_slot, aclk, aresetn, cmd.out_load, st.out_free)
    `GKC_ASSERT_NEXT(a_done_after_load, aclk, aresetn, cmd.out_load, cmd.take)

endmodule

/* design/gkc_datapath.sv */
// Datapath: config registers, example store, distance, kernel, class sums, divider, output word.
`include "gaussian_kernel_classifier_unit_assert.svh"

module gkc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  gkc_pkg::cmd_t      cmd,
    output gkc_pkg::status_t   st,
    input  logic               s_valid,
    input  gkc_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output gkc_pkg::out_word_t m_word,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = gkc_pkg::ADDR_W;

    logic [15:0] inv_sigma_reg;
    logic        calib_reg;
    logic [3:0]  class_count_reg;

    logic [gkc_pkg::POS_W-1:0] pos_reg;
    logic [gkc_pkg::CNT_W-1:0] cnt_reg [gkc_pkg::MAX_CLASSES];
    logic [15:0]               qbuf_reg [gkc_pkg::FEATURE_COUNT];
    logic [15:0]               store_mem [gkc_pkg::STORE_DEPTH];
    logic [15:0]               rd_data_reg;

    logic [gkc_pkg::CLS_W-1:0]   c_reg;
    logic [gkc_pkg::CNT_W-1:0]   j_reg;
    logic [gkc_pkg::EL_W-1:0]    i_reg;
    logic [gkc_pkg::DIST_W-1:0]  d_reg;
    logic [31:0]                 sq_reg;
    logic [43:0]                 prod_reg;
    logic                        big_reg;
    logic [33:0]                 tmul_reg;
    logic                        kz_reg;
    logic [gkc_pkg::SUM_W-1:0]   acc_reg;
    logic [gkc_pkg::SUM_W-1:0]   best_reg;
    logic [gkc_pkg::TOTAL_W-1:0] total_reg;
    logic [2:0]                  winner_reg;
    logic [gkc_pkg::REM_W-1:0]   rem_reg;
    logic [gkc_pkg::QUO_W-1:0]   quo_reg;
    logic [gkc_pkg::DCNT_W-1:0]  dcnt_reg;
    logic                        skip_reg;
    logic                        out_valid_reg;
    gkc_pkg::out_word_t          out_reg;
    gkc_pkg::out_word_t          out_next;

    logic                        in_acc;
    logic [gkc_pkg::ACT_W-1:0]   active;
    logic [gkc_pkg::CIX_W-1:0]   sel_cls;
    logic [gkc_pkg::CNT_W-1:0]   sel_cnt;
    logic [gkc_pkg::CNT_W-1:0]   a_ex;
    logic [gkc_pkg::POS_W-1:0]   a_el;
    logic [AW-1:0]               addr;
    logic                        cls_ok;
    logic                        wr_en;
    logic signed [16:0]          diff;
    logic [16:0]                 diff_abs;
    logic [19:0]                 n_val;
    logic [18:0]                 k_round;
    logic [15:0]                 kernel;
    logic [gkc_pkg::REM_W-1:0]   rem_try;

    assign in_acc = cmd.take && s_valid && aresetn;
    assign active = (gkc_pkg::ACT_W'(class_count_reg) > gkc_pkg::ACT_W'(gkc_pkg::MAX_CLASSES))
                    ? gkc_pkg::ACT_W'(gkc_pkg::MAX_CLASSES) : gkc_pkg::ACT_W'(class_count_reg);
    assign sel_cls = cmd.take ? gkc_pkg::CIX_W'(s_word.class_index)
                              : gkc_pkg::CIX_W'(c_reg);
    assign sel_cnt = cnt_reg[sel_cls];
    assign a_ex    = cmd.take ? sel_cnt : j_reg;
    assign a_el    = cmd.take ? pos_reg : gkc_pkg::POS_W'(i_reg);
    assign addr    = AW'((AW'(sel_cls) * AW'(gkc_pkg::EXAMPLES_PER_CLASS) + AW'(a_ex))
                         * AW'(gkc_pkg::FEATURE_COUNT) + AW'(a_el));
    assign cls_ok  = gkc_pkg::ACT_W'(s_word.class_index) < active;
    assign wr_en   = in_acc && (s_word.func == gkc_pkg::FUNC_STORE) && cls_ok
                     && (sel_cnt < gkc_pkg::CNT_W'(gkc_pkg::EXAMPLES_PER_CLASS))
                     && (pos_reg < gkc_pkg::POS_W'(gkc_pkg::FEATURE_COUNT));

    assign diff     = $signed({qbuf_reg[i_reg][15], qbuf_reg[i_reg]})
                    - $signed({rd_data_reg[15], rd_data_reg});
    assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
    assign n_val    = prod_reg[43:24];
    assign k_round  = 19'((tmul_reg + 34'd32768) >> 16);
    assign kernel   = kz_reg ? 16'd0 : ((k_round > 19'd65535) ? 16'hFFFF : k_round[15:0]);
    assign rem_try  = (dcnt_reg == '0) ? rem_reg : {rem_reg[gkc_pkg::REM_W-2:0], 1'b0};

    always_comb begin
        st.query_end   = s_valid && (s_word.func == gkc_pkg::FUNC_QUERY) && s_word.last_element;
        st.calibrating = calib_reg;
        st.cls_done    = gkc_pkg::ACT_W'(c_reg) >= active;
        st.ex_done     = j_reg >= sel_cnt;
        st.elem_last   = i_reg == gkc_pkg::EL_W'(gkc_pkg::FEATURE_COUNT - 1);
        st.div_last    = dcnt_reg == gkc_pkg::DCNT_W'(gkc_pkg::QUO_W - 1);
        st.out_free    = !out_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[addr] <= s_word.feature_value;
        end
        if (cmd.rd) begin
            rd_data_reg <= store_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && (s_word.func == gkc_pkg::FUNC_QUERY)
            && (pos_reg < gkc_pkg::POS_W'(gkc_pkg::FEATURE_COUNT))) begin
            qbuf_reg[pos_reg[gkc_pkg::EL_W-1:0]] <= s_word.feature_value;
        end
        if (cmd.sq) begin
            sq_reg <= 32'(diff_abs[15:0] * diff_abs[15:0]);
        end
        if (cmd.kmul) begin
            prod_reg <= 44'(d_reg[27:0] * inv_sigma_reg);
            big_reg  <= (d_reg[gkc_pkg::DIST_W-1:28] != '0) && (inv_sigma_reg != 16'd0);
        end
        if (cmd.kexp) begin
            kz_reg   <= big_reg || (n_val >= 20'(gkc_pkg::INT_STEPS));
            tmul_reg <= 34'(gkc_pkg::exp_int(n_val[3:0]) * gkc_pkg::exp_frac(prod_reg[23:20]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_sigma_reg   <= 16'd256;
            calib_reg       <= 1'b0;
            class_count_reg <= 4'd8;
            pos_reg         <= '0;
            for (int k = 0; k < gkc_pkg::MAX_CLASSES; k++) begin
                cnt_reg[k] <= '0;
            end
            c_reg         <= '0;
            j_reg         <= '0;
            i_reg         <= '0;
            d_reg         <= '0;
            acc_reg       <= '0;
            best_reg      <= '0;
            total_reg     <= '0;
            winner_reg    <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            dcnt_reg      <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    gkc_pkg::CFG_INV_SIGMA:   inv_sigma_reg   <= cfg_data;
                    gkc_pkg::CFG_CALIBRATING: calib_reg       <= cfg_data[0];
                    gkc_pkg::CFG_CLASS_COUNT: class_count_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                if (s_word.last_element) begin
                    pos_reg <= '0;
                end else if (pos_reg < gkc_pkg::POS_W'(gkc_pkg::FEATURE_COUNT)) begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if ((s_word.func == gkc_pkg::FUNC_STORE) && s_word.last_element && cls_ok
                    && (sel_cnt < gkc_pkg::CNT_W'(gkc_pkg::EXAMPLES_PER_CLASS))) begin
                    cnt_reg[sel_cls] <= sel_cnt + 1'b1;
                end
                if (st.query_end) begin
                    c_reg      <= '0;
                    j_reg      <= '0;
                    i_reg      <= '0;
                    d_reg      <= '0;
                    acc_reg    <= '0;
                    best_reg   <= '0;
                    total_reg  <= '0;
                    winner_reg <= '0;
                    skip_reg   <= calib_reg;
                end
            end
            if (cmd.acc) begin
                d_reg <= d_reg + gkc_pkg::DIST_W'(sq_reg);
                i_reg <= st.elem_last ? '0 : i_reg + 1'b1;
            end
            if (cmd.kacc) begin
                acc_reg <= acc_reg + gkc_pkg::SUM_W'(kernel);
                j_reg   <= j_reg + 1'b1;
                d_reg   <= '0;
            end
            if (cmd.clend) begin
                total_reg <= total_reg + gkc_pkg::TOTAL_W'(acc_reg);
                if (acc_reg > best_reg) begin
                    best_reg   <= acc_reg;
                    winner_reg <= 3'(c_reg);
                end
                c_reg   <= c_reg + 1'b1;
                j_reg   <= '0;
                acc_reg <= '0;
            end
            if (cmd.div_init) begin
                rem_reg  <= gkc_pkg::REM_W'(best_reg);
                quo_reg  <= '0;
                dcnt_reg <= '0;
            end
            if (cmd.div_step) begin
                if (rem_try >= gkc_pkg::REM_W'(total_reg)) begin
                    rem_reg <= rem_try - gkc_pkg::REM_W'(total_reg);
                    quo_reg <= {quo_reg[gkc_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_try;
                    quo_reg <= {quo_reg[gkc_pkg::QUO_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        out_next = '0;
        if (skip_reg) begin
            out_next.skipped = 1'b1;
        end else if ((total_reg == '0) || (best_reg == '0)) begin
            out_next.no_winner = 1'b1;
        end else begin
            out_next.winner_class       = winner_reg;
            out_next.winner_probability = quo_reg[gkc_pkg::QUO_W-1] ? 16'hFFFF
                                                                    : quo_reg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    `GKC_ASSERT_NEXT(a_load_shows_word, aclk, aresetn, cmd.out_load, out_valid_reg)
    `GKC_ASSERT_NOW(a_flags_exclusive, aclk, aresetn, out_valid_reg, !(out_reg.no_winner && out_reg.skipped))
    `GKC_ASSERT_NEXT(a_rem_below_total, aclk, aresetn, cmd.div_step && (total_reg != '0), rem_reg < gkc_pkg::REM_W'(total_reg))

endmodule

/* tb/gaussian_kernel_classifier_unit_tb.sv */
// Testbench for the Gaussian kernel classifier: directed and random words checked against a local predictor.
module gaussian_kernel_classifier_unit_tb;

    localparam int FEATS = gkc_pkg::FEATURE_COUNT;
    localparam int CLASSES = gkc_pkg::MAX_CLASSES;
    localparam int SLOTS = gkc_pkg::EXAMPLES_PER_CLASS;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 4000;

    logic aclk;
    logic aresetn;
    logic s_valid = 1'b0;
    logic s_ready;
    gkc_pkg::in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    gkc_pkg::out_word_t m_word;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    gaussian_kernel_classifier_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // predictor state
    logic [15:0] inv_sigma = 16'd256;
    logic calib = 1'b0;
    logic [3:0] n_classes = 4'd8;
    logic [15:0] example_mem [CLASSES*SLOTS*FEATS];
    logic [15:0] query_vec [FEATS];
    int slot_fill [CLASSES] = '{default: 0};
    int elem_pos = 0;

    gkc_pkg::out_word_t verdict_q [$];
    gkc_pkg::in_word_t feed_q [$];
    int errors = 0;
    int cycles = 0;
    bit hurry = 0;
    logic s_took = 1'b0;
    logic cfg_took = 1'b0;
    logic m_took = 1'b0;
    int s_gap = 0;
    int r_gap = 0;
    int centers [CLASSES];

    const longint unsigned EXP_N [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                         22, 8, 3, 1};
    const longint unsigned EXP_F [16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                         45042, 42313, 39750, 37341, 35079, 32954,
                                         30957, 29081, 27319, 25664};

    function automatic longint unsigned kernel_of(longint unsigned d2);
        longint unsigned x, n, k;
        x = (d2 * inv_sigma) >> 20;
        n = x >> 4;
        if (n >= 12)
            return 0;
        k = (EXP_N[n] * EXP_F[x & 15] + 32768) >> 16;
        return (k > 65535) ? 65535 : k;
    endfunction

    function automatic longint unsigned dist_sq(int base);
        longint unsigned acc;
        longint d;
        acc = 0;
        for (int i = 0; i < FEATS; i++) begin
            d = longint'($signed(query_vec[i])) - longint'($signed(example_mem[base + i]));
            acc += d * d;
        end
        return acc;
    endfunction

    task automatic classify_word(input gkc_pkg::in_word_t w);
        int pos, act, base, winner;
        longint unsigned sums [CLASSES];
        longint unsigned total, best, prob;
        gkc_pkg::out_word_t r;
        pos = elem_pos;
        act = (n_classes < CLASSES) ? n_classes : CLASSES;
        if (pos < FEATS)
            elem_pos = pos + 1;
        if (w.last_element)
            elem_pos = 0;
        if (w.func == gkc_pkg::FUNC_STORE) begin
            if (w.class_index < act && slot_fill[w.class_index] < SLOTS) begin
                base = (w.class_index * SLOTS + slot_fill[w.class_index]) * FEATS;
                if (pos < FEATS)
                    example_mem[base + pos] = w.feature_value;
                if (w.last_element)
                    slot_fill[w.class_index]++;
            end
            return;
        end
        if (pos < FEATS)
            query_vec[pos] = w.feature_value;
        if (!w.last_element)
            return;
        r = '0;
        if (calib) begin
            r.skipped = 1'b1;
            verdict_q.insert(verdict_q.size(), r);
            return;
        end
        total = 0;
        for (int c = 0; c < CLASSES; c++) begin
            sums[c] = 0;
            if (c < act)
                for (int j = 0; j < slot_fill[c]; j++)
                    sums[c] += kernel_of(dist_sq((c * SLOTS + j) * FEATS));
            sums[c] &= 64'hFFFFFF;
            total += sums[c];
        end
        best = 0;
        winner = 0;
        for (int c = 0; c < act; c++)
            if (sums[c] > best) begin
                best = sums[c];
                winner = c;
            end
        if (total == 0 || best == 0) begin
            r.no_winner = 1'b1;
        end else begin
            prob = (best << 16) / total;
            r.winner_class = winner[2:0];
            r.winner_probability = (prob > 65535) ? 16'hFFFF : prob[15:0];
        end
        verdict_q.insert(verdict_q.size(), r);
    endtask

    // handshake sampling, checking and prediction
    always @(posedge aclk) begin
        gkc_pkg::out_word_t exp_w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("tb: failure");
            $finish;
        end
        s_took <= aresetn && s_valid && s_ready;
        cfg_took <= aresetn && cfg_valid && cfg_ready;
        m_took <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual %p", $time, m_word);
                    errors++;
                end else begin
                    exp_w = verdict_q.pop_front();
                    if (m_word.winner_class !== exp_w.winner_class ||
                        m_word.winner_probability !== exp_w.winner_probability ||
                        m_word.no_winner !== exp_w.no_winner ||
                        m_word.skipped !== exp_w.skipped) begin
                        $display("%0t mismatch: expected %p, actual %p", $time, exp_w, m_word);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                classify_word(s_word);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == gkc_pkg::CFG_INV_SIGMA)
                    inv_sigma = cfg_data;
                else if (cfg_index == gkc_pkg::CFG_CALIBRATING)
                    calib = cfg_data[0];
                else if (cfg_index == gkc_pkg::CFG_CLASS_COUNT)
                    n_classes = cfg_data[3:0];
            end
        end
    end

    // input driver
    always @(negedge aclk) begin
        logic nv;
        gkc_pkg::in_word_t nw;
        nv = s_valid;
        nw = s_word;
        if (!(s_valid && !s_took)) begin
            nv = 1'b0;
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
            end else if (aresetn && feed_q.size() > 0) begin
                nw = feed_q.pop_front();
                nv = 1'b1;
                s_gap = hurry ? 0 : $urandom_range(0, 4);
            end
        end
        s_valid <= nv;
        s_word <= nw;
    end

    // result receiver
    always @(negedge aclk) begin
        if (m_took)
            r_gap = hurry ? 0 : $urandom_range(0, 4);
        if (r_gap > 0) begin
            r_gap = r_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (feed_q.size() > 0 || s_valid || verdict_q.size() > 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic push_vector(input logic f, input logic [2:0] cls, input int len,
                               input int ctr, input int spread);
        gkc_pkg::in_word_t w;
        for (int i = 0; i < len; i++) begin
            w.func = f;
            w.class_index = cls;
            if ($urandom_range(0, 9) == 0)
                w.feature_value = 16'($urandom);
            else
                w.feature_value = 16'(ctr + int'($urandom_range(0, 2 * spread)) - spread);
            w.last_element = (i == len - 1);
            feed_q.insert(feed_q.size(), w);
        end
    endtask

    task automatic random_phase(input int words);
        int pushed, c, len, spread;
        logic [2:0] cls;
        pushed = 0;
        for (int i = 0; i < CLASSES; i++)
            centers[i] = $signed($urandom_range(0, 4000)) - 2000;
        spread = $urandom_range(1, 3) * 40;
        while (pushed < words) begin
            c = $urandom_range(0, 99);
            cls = 3'($urandom_range(0, 7));
            if (c < 50) begin
                len = ($urandom_range(0, 5) == 0) ? FEATS + 1 : FEATS;
                push_vector(gkc_pkg::FUNC_STORE, cls, len, centers[cls], spread);
            end else if (c < 92) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, FEATS + 2) : FEATS;
                push_vector(gkc_pkg::FUNC_QUERY, cls, len, centers[cls], spread);
            end else begin
                len = FEATS;
                push_vector(gkc_pkg::FUNC_QUERY, cls, len,
                            $signed($urandom_range(0, 65535)) - 32768, 32767);
            end
            pushed += len;
        end
        hurry = ($urandom_range(0, 3) == 0);
        drain();
        hurry = 0;
    endtask

    initial begin
        gkc_pkg::in_word_t w;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = gkc_pkg::CFG_INV_SIGMA;
        cfg_data = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extreme example, extreme query, exact match, short query
        for (int i = 0; i < FEATS; i++) begin
            w.func = gkc_pkg::FUNC_STORE;
            w.class_index = 3'd7;
            w.feature_value = (i % 2) ? 16'sh7FFF : 16'sh8000;
            w.last_element = (i == FEATS - 1);
            feed_q.insert(feed_q.size(), w);
        end
        for (int i = 0; i < FEATS; i++) begin
            w.func = gkc_pkg::FUNC_QUERY;
            w.class_index = 3'd0;
            w.feature_value = (i % 2) ? 16'sh8000 : 16'sh7FFF;
            w.last_element = (i == FEATS - 1);
            feed_q.insert(feed_q.size(), w);
        end
        push_vector(gkc_pkg::FUNC_QUERY, 3'd0, 1, 0, 0);
        for (int i = 0; i < FEATS; i++) begin
            w.func = gkc_pkg::FUNC_QUERY;
            w.class_index = 3'd5;
            w.feature_value = (i % 2) ? 16'sh7FFF : 16'sh8000;
            w.last_element = (i == FEATS - 1);
            feed_q.insert(feed_q.size(), w);
        end
        drain();

        random_phase(160);
        write_reg(gkc_pkg::CFG_INV_SIGMA, 16'd1);
        random_phase(160);
        write_reg(gkc_pkg::CFG_INV_SIGMA, 16'hFFFF);
        write_reg(gkc_pkg::CFG_CLASS_COUNT, 16'd3);
        random_phase(140);
        write_reg(gkc_pkg::CFG_CALIBRATING, 16'd1);
        write_reg(gkc_pkg::CFG_INV_SIGMA, 16'd256);
        random_phase(120);
        write_reg(gkc_pkg::CFG_CALIBRATING, 16'd0);
        write_reg(gkc_pkg::CFG_CLASS_COUNT, 16'd0);
        random_phase(100);
        write_reg(gkc_pkg::CFG_CLASS_COUNT, 16'd8);
        write_reg(gkc_pkg::CFG_INV_SIGMA, 16'd64);
        random_phase(180);
        write_reg(gkc_pkg::CFG_CLASS_COUNT, 16'd5);
        write_reg(gkc_pkg::CFG_INV_SIGMA, 16'd4096);
        random_phase(160);
        write_reg(gkc_pkg::CFG_CLASS_COUNT, 16'd8);
        write_reg(gkc_pkg::CFG_INV_SIGMA, 16'd16);
        random_phase(180);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* gaussian_kernel_classifier_unit.f */
+incdir+design
design/gkc_pkg.sv
design/gkc_ctrl.sv
design/gkc_datapath.sv
design/gaussian_kernel_classifier_unit.sv
tb/gaussian_kernel_classifier_unit_tb.sv
